### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands for the port checker, all clocked on clk and
// disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/lslf_pkg.sv
// ----------------------------------------------------------------------------
// lslf_pkg
// Types, widths and codes shared by the line-fit modules.
// ----------------------------------------------------------------------------
package lslf_pkg;

    localparam int MAX_POINTS = 1024;
    localparam int CNT_W      = 11;
    localparam int IN_W       = 16;
    localparam int SUM_W      = 26;
    localparam int SQ_W       = 41;
    localparam int XY_W       = 42;
    localparam int PROD_W     = 53;
    localparam int SPR_W      = 54;
    localparam int MAG_W      = 70;
    localparam int MUL_AW     = 104;
    localparam int MUL_BW     = 56;
    localparam int MUL_PW     = 160;
    localparam int NUM_W      = 88;
    localparam int REM_W      = 54;
    localparam int DIV_CW     = 7;
    localparam int FRAC_SHIFT = 17;
    localparam int RES_W      = 48;
    localparam int CORR_W     = 16;
    localparam int SQ_SHIFT   = 32;

    typedef struct packed {
        logic signed [IN_W-1:0] x_value;
        logic signed [IN_W-1:0] y_value;
        logic                   last_point;
    } point_t;

    typedef struct packed {
        logic signed [RES_W-1:0]  slope;
        logic signed [RES_W-1:0]  intercept;
        logic signed [CORR_W-1:0] correlation;
        logic                     fit_valid;
        logic                     correlation_valid;
        logic                     point_overflow;
        logic [CNT_W-1:0]         point_count;
    } result_t;

    // accumulated sums of one finished data set
    typedef struct packed {
        logic [CNT_W-1:0]        count;
        logic signed [SUM_W-1:0] sum_x;
        logic signed [SUM_W-1:0] sum_y;
        logic [SQ_W-1:0]         sum_x_squared;
        logic [SQ_W-1:0]         sum_y_squared;
        logic signed [XY_W-1:0]  sum_xy;
        logic                    overflow_seen;
    } snap_t;

    typedef struct packed {
        logic              start;
        logic [MUL_AW-1:0] a;
        logic [MUL_BW-1:0] b;
    } mul_req_t;

    typedef struct packed {
        logic              done;
        logic [MUL_PW-1:0] p;
    } mul_rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_MWAIT,
        ST_CALC,
        ST_ICPT,
        ST_DIV_INIT,
        ST_DIV_RUN,
        ST_DIV_END,
        ST_SQ_INIT,
        ST_SQ_CHK,
        ST_SQ_WAIT,
        ST_OUT
    } back_state_t;

    typedef enum logic [3:0] {
        STEP_NXX,
        STEP_SXSQ,
        STEP_NYY,
        STEP_SYSQ,
        STEP_NXY,
        STEP_SXSY,
        STEP_MAGA,
        STEP_MAGB,
        STEP_PSQ,
        STEP_SXY2
    } step_t;

endpackage

### rtl/core/least_squares_line_fit.sv
// ----------------------------------------------------------------------------
// least_squares_line_fit: points enter at one per cycle; a fit uses the bit-serial
// multiplier (up to 16 search products for a full correlation) and, when x has
// spread, two 88-step divisions; two sets may queue, and input stalls while both
// wait.
// Reset clears the sums, the set queue and the result valid flag.
// ----------------------------------------------------------------------------
module least_squares_line_fit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  lslf_pkg::point_t  point,
    output logic              empty,
    input  logic              pop,
    output lslf_pkg::result_t result
);

    logic               accept;
    logic               snap_push;
    lslf_pkg::snap_t    snap_in;
    lslf_pkg::snap_t    snap_out;
    logic               q_full;
    logic               q_empty;
    logic               snap_pop;
    lslf_pkg::mul_req_t mul_req;
    lslf_pkg::mul_rsp_t mul_rsp;

    assign full   = q_full;
    assign accept = push && !q_full;

    lslf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .point     (point),
        .snap_push (snap_push),
        .snap      (snap_in)
    );

    lslf_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (snap_push),
        .din   (snap_in),
        .pop   (snap_pop),
        .dout  (snap_out),
        .full  (q_full),
        .empty (q_empty)
    );

    lslf_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    lslf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .snap_valid (!q_empty),
        .snap       (snap_out),
        .snap_pop   (snap_pop),
        .mul_req    (mul_req),
        .mul_rsp    (mul_rsp),
        .pop        (pop),
        .empty      (empty),
        .result     (result)
    );

endmodule

### rtl/core/lslf_queue.sv
// ----------------------------------------------------------------------------
// lslf_queue
// Two-entry queue of finished data-set sums between front and back.
// ----------------------------------------------------------------------------
module lslf_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  lslf_pkg::snap_t din,
    input  logic            pop,
    output lslf_pkg::snap_t dout,
    output logic            full,
    output logic            empty
);

    logic [1:0]      cnt_reg;
    logic [1:0]      cnt_next;
    lslf_pkg::snap_t head_reg;
    lslf_pkg::snap_t tail_reg;
    logic            push_eff;
    logic            pop_eff;

    assign full     = (cnt_reg == 2'd2);
    assign empty    = (cnt_reg == 2'd0);
    assign push_eff = push && !full;
    assign pop_eff  = pop && !empty;
    assign dout     = head_reg;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push_eff && !pop_eff)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (pop_eff && !push_eff)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_eff && pop_eff)
        begin
            if (cnt_reg == 2'd1)
            begin
                head_reg <= din;
            end
            else
            begin
                head_reg <= tail_reg;
                tail_reg <= din;
            end
        end
        else if (push_eff)
        begin
            if (cnt_reg == 2'd0)
            begin
                head_reg <= din;
            end
            else
            begin
                tail_reg <= din;
            end
        end
        else if (pop_eff)
        begin
            head_reg <= tail_reg;
        end
    end

endmodule

### rtl/core/lslf_front.sv
// ----------------------------------------------------------------------------
// lslf_front
// Point accumulator: count and running sums, one point per cycle.
// ----------------------------------------------------------------------------
module lslf_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  lslf_pkg::point_t point,
    output logic             snap_push,
    output lslf_pkg::snap_t  snap
);

    logic [lslf_pkg::CNT_W-1:0]        count_reg, count_next;
    logic signed [lslf_pkg::SUM_W-1:0] sum_x_reg, sum_x_next;
    logic signed [lslf_pkg::SUM_W-1:0] sum_y_reg, sum_y_next;
    logic [lslf_pkg::SQ_W-1:0]         sxx_reg, sxx_next;
    logic [lslf_pkg::SQ_W-1:0]         syy_reg, syy_next;
    logic signed [lslf_pkg::XY_W-1:0]  sxy_reg, sxy_next;
    logic                              ovf_reg, ovf_next;
    logic signed [31:0]                xx, yy, xy;
    logic                              take;

    always_comb
    begin
        take       = (count_reg < lslf_pkg::CNT_W'(lslf_pkg::MAX_POINTS));
        xx         = point.x_value * point.x_value;
        yy         = point.y_value * point.y_value;
        xy         = point.x_value * point.y_value;
        count_next = count_reg;
        sum_x_next = sum_x_reg;
        sum_y_next = sum_y_reg;
        sxx_next   = sxx_reg;
        syy_next   = syy_reg;
        sxy_next   = sxy_reg;
        ovf_next   = ovf_reg;
        if (take)
        begin
            count_next = count_reg + lslf_pkg::CNT_W'(1);
            sum_x_next = sum_x_reg + lslf_pkg::SUM_W'(point.x_value);
            sum_y_next = sum_y_reg + lslf_pkg::SUM_W'(point.y_value);
            sxx_next   = sxx_reg + lslf_pkg::SQ_W'($unsigned(xx));
            syy_next   = syy_reg + lslf_pkg::SQ_W'($unsigned(yy));
            sxy_next   = sxy_reg + lslf_pkg::XY_W'(xy);
        end
        else
        begin
            ovf_next = 1'b1;
        end
    end

    assign snap_push          = accept && point.last_point;
    assign snap.count         = count_next;
    assign snap.sum_x         = sum_x_next;
    assign snap.sum_y         = sum_y_next;
    assign snap.sum_x_squared = sxx_next;
    assign snap.sum_y_squared = syy_next;
    assign snap.sum_xy        = sxy_next;
    assign snap.overflow_seen = ovf_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            sum_x_reg <= '0;
            sum_y_reg <= '0;
            sxx_reg   <= '0;
            syy_reg   <= '0;
            sxy_reg   <= '0;
            ovf_reg   <= 1'b0;
        end
        else if (accept)
        begin
            if (point.last_point)
            begin
                count_reg <= '0;
                sum_x_reg <= '0;
                sum_y_reg <= '0;
                sxx_reg   <= '0;
                syy_reg   <= '0;
                sxy_reg   <= '0;
                ovf_reg   <= 1'b0;
            end
            else
            begin
                count_reg <= count_next;
                sum_x_reg <= sum_x_next;
                sum_y_reg <= sum_y_next;
                sxx_reg   <= sxx_next;
                syy_reg   <= syy_next;
                sxy_reg   <= sxy_next;
                ovf_reg   <= ovf_next;
            end
        end
    end

endmodule

### rtl/core/lslf_mul.sv
// ----------------------------------------------------------------------------
// lslf_mul
// Shift-add unsigned multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module lslf_mul (
    input  logic               clk,
    input  logic               rst_n,
    input  lslf_pkg::mul_req_t req,
    output lslf_pkg::mul_rsp_t rsp
);

    logic                         run_reg;
    logic                         done_reg;
    logic [lslf_pkg::MUL_PW-1:0]  a_reg;
    logic [lslf_pkg::MUL_BW-1:0]  b_reg;
    logic [lslf_pkg::MUL_PW-1:0]  acc_reg;

    assign rsp.done = done_reg;
    assign rsp.p    = acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                run_reg <= 1'b1;
            end
            else if (run_reg && (b_reg == '0))
            begin
                run_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            a_reg   <= lslf_pkg::MUL_PW'(req.a);
            b_reg   <= req.b;
            acc_reg <= '0;
        end
        else if (run_reg && (b_reg != '0))
        begin
            if (b_reg[0])
            begin
                acc_reg <= acc_reg + a_reg;
            end
            a_reg <= a_reg << 1;
            b_reg <= b_reg >> 1;
        end
    end

endmodule

### rtl/core/lslf_back.sv
// ----------------------------------------------------------------------------
// lslf_back
// Fit sequencer: spreads, slope and intercept division, correlation search,
// and the result register.
// ----------------------------------------------------------------------------
module lslf_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               snap_valid,
    input  lslf_pkg::snap_t    snap,
    output logic               snap_pop,
    output lslf_pkg::mul_req_t mul_req,
    input  lslf_pkg::mul_rsp_t mul_rsp,
    input  logic               pop,
    output logic               empty,
    output lslf_pkg::result_t  result
);

    lslf_pkg::back_state_t state_reg, state_next;
    lslf_pkg::step_t       step_reg;
    lslf_pkg::snap_t       snap_reg;

    logic [lslf_pkg::PROD_W-1:0]       nxx_reg, sxsq_reg, nyy_reg, sysq_reg, nxy_reg, sxsy_reg;
    logic [lslf_pkg::MAG_W-1:0]        mag_a_reg, mag_b_reg, icpt_mag_reg;
    logic                              icpt_neg_reg;
    logic [lslf_pkg::MUL_AW-1:0]       pp_reg;
    logic [lslf_pkg::MUL_PW-1:0]       rhs_reg;
    logic signed [lslf_pkg::SPR_W-1:0] sxx_reg, syy_reg, sxy_reg;
    logic signed [lslf_pkg::SPR_W-1:0] sxx_next, syy_next, sxy_next;
    logic                              fit_ok_reg, corr_ok_reg, fit_ok_next;

    logic [lslf_pkg::NUM_W-1:0]        num_reg, quo_reg;
    logic [lslf_pkg::REM_W-1:0]        rem_reg;
    logic [lslf_pkg::DIV_CW-1:0]       dcnt_reg;
    logic                              dneg_reg, dsel_reg;

    logic signed [lslf_pkg::RES_W-1:0] slope_reg, icpt_reg;
    logic [15:0]                       lo_reg, hi_reg, mid_reg;
    lslf_pkg::result_t                 res_reg, res_next;
    logic                              res_valid_reg;
    logic                              out_write;

    // operand magnitudes
    logic [lslf_pkg::SUM_W-1:0]        abs_sx, abs_sy;
    logic [lslf_pkg::XY_W-1:0]         abs_sxy;
    logic [lslf_pkg::SPR_W-1:0]        abs_spr_xy;
    logic signed [lslf_pkg::SPR_W-1:0] term_nxy, term_sxsy;

    // correlation search
    logic [16:0]                       mid_sum;
    logic [15:0]                       mid;
    logic [15:0]                       kval;
    logic [31:0]                       ksq;
    logic                              sq_more;

    // divider step and rounding
    logic [lslf_pkg::REM_W-1:0]        rem_shift;
    logic [lslf_pkg::REM_W-1:0]        den;
    logic                              rem_ge;
    logic                              div_last;
    logic                              q_sat;
    logic [48:0]                       q_half, q_lim, q_val;
    logic [lslf_pkg::RES_W-1:0]        q_signed;

    logic                              neg_a, neg_c;
    logic [lslf_pkg::CORR_W-1:0]       corr_pos, corr_val;

    assign empty  = !res_valid_reg;
    assign result = res_reg;

    always_comb
    begin
        abs_sx  = snap_reg.sum_x[lslf_pkg::SUM_W-1] ? $unsigned(-snap_reg.sum_x)
                                                    : $unsigned(snap_reg.sum_x);
        abs_sy  = snap_reg.sum_y[lslf_pkg::SUM_W-1] ? $unsigned(-snap_reg.sum_y)
                                                    : $unsigned(snap_reg.sum_y);
        abs_sxy = snap_reg.sum_xy[lslf_pkg::XY_W-1] ? $unsigned(-snap_reg.sum_xy)
                                                    : $unsigned(snap_reg.sum_xy);
        abs_spr_xy = sxy_reg[lslf_pkg::SPR_W-1] ? $unsigned(-sxy_reg) : $unsigned(sxy_reg);

        term_nxy  = $signed(lslf_pkg::SPR_W'(nxy_reg));
        term_sxsy = $signed(lslf_pkg::SPR_W'(sxsy_reg));
        if (snap_reg.sum_xy[lslf_pkg::XY_W-1])
        begin
            term_nxy = -term_nxy;
        end
        if (snap_reg.sum_x[lslf_pkg::SUM_W-1] != snap_reg.sum_y[lslf_pkg::SUM_W-1])
        begin
            term_sxsy = -term_sxsy;
        end
        sxx_next = $signed(lslf_pkg::SPR_W'(nxx_reg)) - $signed(lslf_pkg::SPR_W'(sxsq_reg));
        syy_next = $signed(lslf_pkg::SPR_W'(nyy_reg)) - $signed(lslf_pkg::SPR_W'(sysq_reg));
        sxy_next = term_nxy - term_sxsy;
        fit_ok_next = !sxx_next[lslf_pkg::SPR_W-1] && (sxx_next != '0);

        // intercept numerator sign terms: sum_x2*sum_y and -sum_x*sum_xy
        neg_a = snap_reg.sum_y[lslf_pkg::SUM_W-1];
        neg_c = (snap_reg.sum_x[lslf_pkg::SUM_W-1] == snap_reg.sum_xy[lslf_pkg::XY_W-1]);

        mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg} + 17'd1;
        mid     = mid_sum[16:1];
        kval    = 16'(({1'b0, mid} << 1) - 17'd1);
        ksq     = kval * kval;
        sq_more = (lo_reg < hi_reg);

        den       = $unsigned(sxx_reg);
        rem_shift = {rem_reg[lslf_pkg::REM_W-2:0], num_reg[lslf_pkg::NUM_W-1]};
        rem_ge    = (rem_shift >= den);
        div_last  = (dcnt_reg == lslf_pkg::DIV_CW'(lslf_pkg::NUM_W - 1));

        q_sat  = |quo_reg[lslf_pkg::NUM_W-1:49];
        q_half = quo_reg[49:1] + 49'(quo_reg[0]);
        q_lim  = dneg_reg ? (49'd1 << 47) : ((49'd1 << 47) - 49'd1);
        q_val  = (q_sat || (q_half > q_lim)) ? q_lim : q_half;
        q_signed = dneg_reg ? -q_val[lslf_pkg::RES_W-1:0] : q_val[lslf_pkg::RES_W-1:0];

        corr_pos = (lo_reg > 16'd32767) ? 16'd32767 : lo_reg;
        corr_val = sxy_reg[lslf_pkg::SPR_W-1] ? -lo_reg : corr_pos;
    end

    always_comb
    begin
        res_next.slope             = slope_reg;
        res_next.intercept         = icpt_reg;
        res_next.correlation       = corr_ok_reg ? $signed(corr_val) : '0;
        res_next.fit_valid         = fit_ok_reg;
        res_next.correlation_valid = corr_ok_reg;
        res_next.point_overflow    = snap_reg.overflow_seen;
        res_next.point_count       = snap_reg.count;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lslf_pkg::ST_IDLE:
                if (snap_valid) state_next = lslf_pkg::ST_MUL;
            lslf_pkg::ST_MUL:
                state_next = lslf_pkg::ST_MWAIT;
            lslf_pkg::ST_MWAIT:
                if (mul_rsp.done)
                begin
                    if (step_reg == lslf_pkg::STEP_SXSY)
                        state_next = lslf_pkg::ST_CALC;
                    else if (step_reg == lslf_pkg::STEP_MAGB)
                        state_next = lslf_pkg::ST_ICPT;
                    else if (step_reg == lslf_pkg::STEP_SXY2)
                        state_next = lslf_pkg::ST_SQ_INIT;
                    else
                        state_next = lslf_pkg::ST_MUL;
                end
            lslf_pkg::ST_CALC:
                state_next = fit_ok_next ? lslf_pkg::ST_MUL : lslf_pkg::ST_OUT;
            lslf_pkg::ST_ICPT:
                state_next = lslf_pkg::ST_DIV_INIT;
            lslf_pkg::ST_DIV_INIT:
                state_next = lslf_pkg::ST_DIV_RUN;
            lslf_pkg::ST_DIV_RUN:
                if (div_last) state_next = lslf_pkg::ST_DIV_END;
            lslf_pkg::ST_DIV_END:
                if (!dsel_reg)
                    state_next = lslf_pkg::ST_DIV_INIT;
                else
                    state_next = corr_ok_reg ? lslf_pkg::ST_MUL : lslf_pkg::ST_OUT;
            lslf_pkg::ST_SQ_INIT:
                state_next = lslf_pkg::ST_SQ_CHK;
            lslf_pkg::ST_SQ_CHK:
                state_next = sq_more ? lslf_pkg::ST_SQ_WAIT : lslf_pkg::ST_OUT;
            lslf_pkg::ST_SQ_WAIT:
                if (mul_rsp.done) state_next = lslf_pkg::ST_SQ_CHK;
            lslf_pkg::ST_OUT:
                if (!res_valid_reg || pop) state_next = lslf_pkg::ST_IDLE;
            default:
                state_next = lslf_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        snap_pop      = 1'b0;
        out_write     = 1'b0;
        mul_req.start = 1'b0;
        mul_req.a     = '0;
        mul_req.b     = '0;
        unique case (state_reg)
            lslf_pkg::ST_IDLE:
                snap_pop = snap_valid;
            lslf_pkg::ST_MUL:
            begin
                mul_req.start = 1'b1;
                unique case (step_reg)
                    lslf_pkg::STEP_NXX:
                    begin
                        mul_req.a = lslf_pkg::MUL_AW'(snap_reg.sum_x_squared);
                        mul_req.b = lslf_pkg::MUL_BW'(snap_reg.count);
                    end
                    lslf_pkg::STEP_SXSQ:
                    begin
                        mul_req.a = lslf_pkg::MUL_AW'(abs_sx);
                        mul_req.b = lslf_pkg::MUL_BW'(abs_sx);
                    end
                    lslf_pkg::STEP_NYY:
                    begin
                        mul_req.a = lslf_pkg::MUL_AW'(snap_reg.sum_y_squared);
                        mul_req.b = lslf_pkg::MUL_BW'(snap_reg.count);
                    end
                    lslf_pkg::STEP_SYSQ:
                    begin
                        mul_req.a = lslf_pkg::MUL_AW'(abs_sy);
                        mul_req.b = lslf_pkg::MUL_BW'(abs_sy);
                    end
                    lslf_pkg::STEP_NXY:
                    begin
                        mul_req.a = lslf_pkg::MUL_AW'(abs_sxy);
                        mul_req.b = lslf_pkg::MUL_BW'(snap_reg.count);
                    end
                    lslf_pkg::STEP_SXSY:
                    begin
                        mul_req.a = lslf_pkg::MUL_AW'(abs_sx);
                        mul_req.b = lslf_pkg::MUL_BW'(abs_sy);
                    end
                    lslf_pkg::STEP_MAGA:
                    begin
                        mul_req.a = lslf_pkg::MUL_AW'(snap_reg.sum_x_squared);
                        mul_req.b = lslf_pkg::MUL_BW'(abs_sy);
                    end
                    lslf_pkg::STEP_MAGB:
                    begin
                        mul_req.a = lslf_pkg::MUL_AW'(abs_sxy);
                        mul_req.b = lslf_pkg::MUL_BW'(abs_sx);
                    end
                    lslf_pkg::STEP_PSQ:
                    begin
                        mul_req.a = lslf_pkg::MUL_AW'($unsigned(sxx_reg));
                        mul_req.b = lslf_pkg::MUL_BW'($unsigned(syy_reg));
                    end
                    lslf_pkg::STEP_SXY2:
                    begin
                        mul_req.a = lslf_pkg::MUL_AW'(abs_spr_xy);
                        mul_req.b = lslf_pkg::MUL_BW'(abs_spr_xy);
                    end
                    default:
                    begin
                        mul_req.a = '0;
                        mul_req.b = '0;
                    end
                endcase
            end
            lslf_pkg::ST_SQ_CHK:
            begin
                mul_req.start = sq_more;
                mul_req.a     = pp_reg;
                mul_req.b     = lslf_pkg::MUL_BW'(ksq);
            end
            lslf_pkg::ST_OUT:
                out_write = !res_valid_reg || pop;
            default:
                snap_pop = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lslf_pkg::ST_IDLE;
            step_reg      <= lslf_pkg::STEP_NXX;
            dcnt_reg      <= '0;
            dsel_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (snap_pop)
            begin
                step_reg <= lslf_pkg::STEP_NXX;
            end
            else if ((state_reg == lslf_pkg::ST_MWAIT) && mul_rsp.done)
            begin
                step_reg <= lslf_pkg::step_t'(step_reg + 4'd1);
            end
            if (state_reg == lslf_pkg::ST_ICPT)
            begin
                dsel_reg <= 1'b0;
            end
            else if (state_reg == lslf_pkg::ST_DIV_END)
            begin
                dsel_reg <= 1'b1;
            end
            if (state_reg == lslf_pkg::ST_DIV_INIT)
            begin
                dcnt_reg <= '0;
            end
            else if (state_reg == lslf_pkg::ST_DIV_RUN)
            begin
                dcnt_reg <= dcnt_reg + lslf_pkg::DIV_CW'(1);
            end
            if (out_write)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (snap_pop)
        begin
            snap_reg    <= snap;
            slope_reg   <= '0;
            icpt_reg    <= '0;
            lo_reg      <= '0;
            fit_ok_reg  <= 1'b0;
            corr_ok_reg <= 1'b0;
        end
        if ((state_reg == lslf_pkg::ST_MWAIT) && mul_rsp.done)
        begin
            unique case (step_reg)
                lslf_pkg::STEP_NXX:  nxx_reg   <= lslf_pkg::PROD_W'(mul_rsp.p);
                lslf_pkg::STEP_SXSQ: sxsq_reg  <= lslf_pkg::PROD_W'(mul_rsp.p);
                lslf_pkg::STEP_NYY:  nyy_reg   <= lslf_pkg::PROD_W'(mul_rsp.p);
                lslf_pkg::STEP_SYSQ: sysq_reg  <= lslf_pkg::PROD_W'(mul_rsp.p);
                lslf_pkg::STEP_NXY:  nxy_reg   <= lslf_pkg::PROD_W'(mul_rsp.p);
                lslf_pkg::STEP_SXSY: sxsy_reg  <= lslf_pkg::PROD_W'(mul_rsp.p);
                lslf_pkg::STEP_MAGA: mag_a_reg <= lslf_pkg::MAG_W'(mul_rsp.p);
                lslf_pkg::STEP_MAGB: mag_b_reg <= lslf_pkg::MAG_W'(mul_rsp.p);
                lslf_pkg::STEP_PSQ:  pp_reg    <= lslf_pkg::MUL_AW'(mul_rsp.p);
                lslf_pkg::STEP_SXY2: rhs_reg   <= mul_rsp.p << lslf_pkg::SQ_SHIFT;
                default:             pp_reg    <= pp_reg;
            endcase
        end
        if (state_reg == lslf_pkg::ST_CALC)
        begin
            sxx_reg     <= sxx_next;
            syy_reg     <= syy_next;
            sxy_reg     <= sxy_next;
            fit_ok_reg  <= fit_ok_next;
            corr_ok_reg <= fit_ok_next && !syy_next[lslf_pkg::SPR_W-1] && (syy_next != '0);
        end
        if (state_reg == lslf_pkg::ST_ICPT)
        begin
            if (neg_a == neg_c)
            begin
                icpt_mag_reg <= mag_a_reg + mag_b_reg;
                icpt_neg_reg <= neg_a;
            end
            else if (mag_a_reg >= mag_b_reg)
            begin
                icpt_mag_reg <= mag_a_reg - mag_b_reg;
                icpt_neg_reg <= neg_a;
            end
            else
            begin
                icpt_mag_reg <= mag_b_reg - mag_a_reg;
                icpt_neg_reg <= neg_c;
            end
        end
        if (state_reg == lslf_pkg::ST_DIV_INIT)
        begin
            rem_reg <= '0;
            quo_reg <= '0;
            if (!dsel_reg)
            begin
                num_reg  <= lslf_pkg::NUM_W'(abs_spr_xy) << lslf_pkg::FRAC_SHIFT;
                dneg_reg <= sxy_reg[lslf_pkg::SPR_W-1];
            end
            else
            begin
                num_reg  <= lslf_pkg::NUM_W'(icpt_mag_reg) << lslf_pkg::FRAC_SHIFT;
                dneg_reg <= icpt_neg_reg;
            end
        end
        if (state_reg == lslf_pkg::ST_DIV_RUN)
        begin
            rem_reg <= rem_ge ? (rem_shift - den) : rem_shift;
            quo_reg <= {quo_reg[lslf_pkg::NUM_W-2:0], rem_ge};
            num_reg <= num_reg << 1;
        end
        if (state_reg == lslf_pkg::ST_DIV_END)
        begin
            if (!dsel_reg)
                slope_reg <= $signed(q_signed);
            else
                icpt_reg <= $signed(q_signed);
        end
        if (state_reg == lslf_pkg::ST_SQ_INIT)
        begin
            lo_reg <= '0;
            hi_reg <= 16'd32768;
        end
        if ((state_reg == lslf_pkg::ST_SQ_CHK) && sq_more)
        begin
            mid_reg <= mid;
        end
        if ((state_reg == lslf_pkg::ST_SQ_WAIT) && mul_rsp.done)
        begin
            if (mul_rsp.p <= rhs_reg)
                lo_reg <= mid_reg;
            else
                hi_reg <= mid_reg - 16'd1;
        end
        if (out_write)
        begin
            res_reg <= res_next;
        end
    end

endmodule

### rtl/core/lslf_checker.sv
// ----------------------------------------------------------------------------
// lslf_checker
// Port-level checks on the result side of the line-fit block, and on accepted points.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lslf_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              push,
    input logic              full,
    input lslf_pkg::point_t  point,
    input logic              empty,
    input logic              pop,
    input lslf_pkg::result_t result
);

    `ASSERT_NEXT(a_res_hold, !empty && !pop, !empty && $stable(result), "result word changed while stalled")
    `ASSERT_IMPLY(a_nofit_zero, !empty && !result.fit_valid, (result.slope == '0) && (result.intercept == '0), "slope or intercept nonzero without fit")
    `ASSERT_IMPLY(a_corr_needs_fit, !empty && result.correlation_valid, result.fit_valid, "correlation valid without fit")
    `ASSERT_IMPLY(a_nocorr_zero, !empty && !result.correlation_valid, result.correlation == '0, "correlation nonzero while invalid")
    `ASSERT_IMPLY(a_point_known, push && !full, !$isunknown(point), "point word unknown when accepted")

endmodule

bind least_squares_line_fit lslf_checker u_lslf_checker (.*);
